### rtl/dhe_pkg.sv
// Shared types and constants for the depth histogram equalizer.
package dhe_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int INT_BITS   = 8;
  localparam int DIV_STEPS  = 8;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic                  frame_end;
  } in_word_t;

  typedef struct packed {
    logic [INT_BITS-1:0] intensity;
    logic                frame_done;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic cnt_upd;
    logic map_out;
    logic clr_wr;
    logic idx_clr;
    logic idx_inc;
    logic wk_rd;
    logic wk_acc;
    logic div_step;
    logic wk_wr;
    logic total_clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic idx_last;
    logic skip;
    logic div_done;
  } sts_t;

endpackage

### rtl/dhe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhe_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/dhe_ctrl.sv
// Controller state machine: sequences counting, bin walk, mapping and clearing.
module dhe_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  dhe_pkg::sts_t sts,
  output dhe_pkg::cmd_t cmd
);
  import dhe_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_MAP  = 3'd3;
  localparam logic [2:0] S_WRD  = 3'd4;
  localparam logic [2:0] S_WACC = 3'd5;
  localparam logic [2:0] S_WDIV = 3'd6;
  localparam logic [2:0] S_WWR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = phase_r ? S_MAP : S_CNT;
        end
      end
      S_CNT: begin
        cmd.cnt_upd = 1'b1;
        if (sts.last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_WRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAP: begin
        cmd.map_out = 1'b1;
        if (sts.last) begin
          cmd.total_clr = 1'b1;
          cmd.idx_clr   = 1'b1;
          phase_nxt     = 1'b0;
          state_nxt     = S_CLR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WRD: begin
        cmd.wk_rd = 1'b1;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        cmd.wk_acc = 1'b1;
        state_nxt  = sts.skip ? S_WWR : S_WDIV;
      end
      S_WDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_WWR;
        end
      end
      S_WWR: begin
        cmd.wk_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          phase_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WRD;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTH
  a_map_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.map_out |-> phase_r)
    else $error("mapping output outside the mapping phase");

  a_cnt_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_upd |-> !phase_r)
    else $error("count update outside the counting phase");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WDIV && !sts.div_done) |=> (state_r == S_WDIV))
    else $error("division left before its last step");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP && sts.last) |=> (state_r == S_CLR && !phase_r))
    else $error("end of mapping pass did not start the clearing sweep");
`endif

endmodule

### rtl/dhe_dp.sv
// Datapath: bin store, counters, running sum, serial divider and result register.
module dhe_dp #(
  parameter int BINS       = 16384,
  parameter int COUNT_BITS = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dhe_pkg::in_word_t in_word,
  input  dhe_pkg::cmd_t     cmd,
  output dhe_pkg::sts_t     sts,
  output logic              out_valid,
  output dhe_pkg::out_word_t out_word
);
  import dhe_pkg::*;

  localparam int BIN_BITS = $clog2(BINS);
  localparam int CB       = COUNT_BITS;
  localparam logic [CB-1:0]         CNT_MAX  = '1;
  localparam logic [BIN_BITS-1:0]   IDX_LAST = BIN_BITS'(BINS - 1);
  localparam logic [DEPTH_BITS:0]   TOP_BIN  = (DEPTH_BITS + 1)'(BINS - 1);

  // Depths beyond the top bin land in the top bin.
  function automatic logic [BIN_BITS-1:0] bin_of(input logic [DEPTH_BITS-1:0] d);
    if ({1'b0, d} > TOP_BIN) begin
      return IDX_LAST;
    end
    return d[BIN_BITS-1:0];
  endfunction

  logic [DEPTH_BITS-1:0] depth_r;
  logic                  last_r;
  logic [BIN_BITS-1:0]   idx_r, idx_nxt;
  logic [CB-1:0]         total_r, total_nxt;
  logic [CB-1:0]         cum_r, cum_nxt;
  logic [CB-1:0]         rem_r, rem_nxt;
  logic [INT_BITS-1:0]   quo_r, quo_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic                  out_valid_r;
  out_word_t             out_word_r, out_word_nxt;

  logic                  ram_we, ram_re;
  logic [BIN_BITS-1:0]   ram_waddr, ram_raddr;
  logic [CB-1:0]         ram_wdata, ram_rdata;

  logic [CB:0]           cum_sum;
  logic [CB-1:0]         cum_new;
  logic [CB:0]           rem2;
  logic                  rem_ge;
  logic                  skip;

  dhe_ram #(
    .WIDTH (CB),
    .DEPTH (BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Running sum saturates; only its order against the total matters.
  assign cum_sum = {1'b0, cum_r} + {1'b0, ram_rdata};
  assign cum_new = cum_sum[CB] ? CNT_MAX : cum_sum[CB-1:0];
  assign skip    = (total_r == '0) || (cum_new >= total_r) || (idx_r == '0);

  // One restoring step: the remainder never exceeds the total.
  assign rem2    = {rem_r, 1'b0};
  assign rem_ge  = (rem2 >= {1'b0, total_r});

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    if (cmd.accept) begin
      ram_re    = 1'b1;
      ram_raddr = bin_of(in_word.depth);
    end else if (cmd.wk_rd) begin
      ram_re = 1'b1;
    end

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    if (cmd.cnt_upd) begin
      ram_we    = (depth_r != '0);
      ram_waddr = bin_of(depth_r);
      ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CB'(1);
    end else if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.wk_wr) begin
      ram_we    = 1'b1;
      ram_wdata = CB'(quo_r);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + BIN_BITS'(1);
    end

    total_nxt = total_r;
    if (cmd.total_clr) begin
      total_nxt = '0;
    end else if (cmd.cnt_upd && depth_r != '0 && total_r != CNT_MAX) begin
      total_nxt = total_r + CB'(1);
    end

    cum_nxt  = cum_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    if (cmd.idx_clr) begin
      cum_nxt = '0;
    end
    if (cmd.wk_acc) begin
      cum_nxt  = cum_new;
      rem_nxt  = total_r - cum_new;
      quo_nxt  = '0;
      step_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt  = rem_ge ? CB'(rem2 - {1'b0, total_r}) : rem2[CB-1:0];
      quo_nxt  = {quo_r[INT_BITS-2:0], rem_ge};
      step_nxt = step_r + STEP_BITS'(1);
    end

    out_word_nxt            = out_word_r;
    out_word_nxt.intensity  = (depth_r == '0) ? '0 : ram_rdata[INT_BITS-1:0];
    out_word_nxt.frame_done = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      total_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      step_r      <= step_nxt;
      out_valid_r <= cmd.map_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_r <= in_word.depth;
      last_r  <= in_word.frame_end;
    end
    cum_r <= cum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.map_out) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign sts.last     = last_r;
  assign sts.idx_last = (idx_r == IDX_LAST);
  assign sts.skip     = skip;
  assign sts.div_done = (step_r == STEP_BITS'(DIV_STEPS - 1));

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/depth_histogram_equalizer.sv
// Top level of the depth histogram equalizer: controller plus datapath.
//
//  Channel   Ports                     Handshake
//  input     start, busy, in_word      word taken at a clock edge with start high, busy low
//  result    out_valid, out_word       word shown for one cycle, taken at the edge ending it
//
// Words: each input word is a read-modify-write on the single-port-pair bin store, read at
// the accept edge, with the write or result registered in the next cycle; busy stays high
// until then, so the next word waits. At the end of the counting pass the bin walk reads,
// accumulates, divides and writes back each bin, but bin zero and each bin at which the
// running sum has reached the total (every bin of an empty frame) skip the bit-serial divider.
// Reset: a clearing sweep writes zero to all BINS entries with busy high;
// the same sweep runs after the last word of every mapping pass.
// Stalls: the receiver cannot stall; the result register frees the input side, so the next
// word is taken in the same cycle that the previous result is shown.
module depth_histogram_equalizer #(
  parameter int BINS       = 16384,
  parameter int COUNT_BITS = 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dhe_pkg::in_word_t  in_word,
  output logic               out_valid,
  output dhe_pkg::out_word_t out_word
);
  import dhe_pkg::*;

  // Commands and status are the only link between the two halves.
  cmd_t cmd;
  sts_t sts;

  // The controller owns the pass (counting or mapping) and all sequencing.
  dhe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the bin store, the nonzero total, the running sum and the
  // divider that turns each remaining count into an intensity.
  dhe_dp #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### test/depth_histogram_equalizer_tb.sv
// Self-checking testbench for the depth histogram equalizer: directed table, then random frames.
module depth_histogram_equalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dhe_pkg::*;

  // Same sizes as the default build of the block.
  localparam int BINS       = 16384;
  localparam int COUNT_BITS = 19;
  localparam int BIN_BITS   = $clog2(BINS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // The random part stops once about this many words have been taken.
  localparam int WORD_TARGET = 1250;

  // Words in this index range are sent back to back, with no idle cycles.
  localparam int QUIET_FIRST = 500;
  localparam int QUIET_LAST  = 800;

  // Percentage of cycles in which the sender idles outside the quiet range.
  localparam int IDLE_PCT = 26;

  // One row of the directed table. Where has_fixed is set, the row carries an
  // expected intensity that can be read straight off the behavior; the predictor
  // still runs on that row so that its state stays in step with the block.
  typedef struct {
    logic [DEPTH_BITS-1:0] depth;
    bit                    last;
    bit                    has_fixed;
    logic [INT_BITS-1:0]   fixed_int;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Predictor state: histogram counts during the counting pass, per-bin
  // intensities during the mapping pass.
  logic [COUNT_BITS-1:0] hist_bins [BINS];
  logic [COUNT_BITS-1:0] hist_total;
  bit                    in_map_pass;

  // Expected result words, oldest first.
  out_word_t intensity_q [$];

  // Depths seen in the current counting pass, reused for the mapping pass.
  logic [DEPTH_BITS-1:0] frame_depths [$];

  stim_row_t dir_rows [DIR_ROWS];
  int        words_sent;
  int        fail_cnt;

  depth_histogram_equalizer #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Turns the counts into intensities: a running sum over the bins in ascending
  // order, and floor(256 * (total - sum) / total) per bin from bin 1 upward.
  // Bins at or above the point where the sum reaches the total map to zero, and
  // so does every bin of an empty frame. Bin zero never counts and maps to zero.
  task automatic build_intensity_lut();
    longint unsigned cum;
    longint unsigned total;
    longint unsigned val;
    cum   = 64'(hist_bins[0]);
    total = 64'(hist_total);
    for (int i = 1; i < BINS; i++) begin
      cum += 64'(hist_bins[i]);
      val = 0;
      if (total != 0 && cum < total) begin
        val = (256 * (total - cum)) / total;
        // A bin below the first occupied one gives 256, which is clamped.
        if (val > 255) val = 255;
      end
      hist_bins[i] = val[COUNT_BITS-1:0];
    end
    hist_bins[0] = '0;
  endtask

  // Advances the predictor by one accepted word and returns the result word
  // that it causes, if any.
  task automatic predict_intensity(input in_word_t w, output bit has_res,
                                   output out_word_t res);
    logic [BIN_BITS-1:0] b;
    // Depths above the top bin are clamped into it.
    b       = (w.depth > BINS - 1) ? BIN_BITS'(BINS - 1) : w.depth[BIN_BITS-1:0];
    res     = '0;
    has_res = 1'b0;
    if (!in_map_pass) begin
      if (w.depth != 0) begin
        if (hist_bins[b] < COUNT_MAX) hist_bins[b]++;
        if (hist_total < COUNT_MAX) hist_total++;
      end
      if (w.frame_end) begin
        build_intensity_lut();
        in_map_pass = 1'b1;
      end
    end else begin
      has_res        = 1'b1;
      res.intensity  = (w.depth == 0) ? '0 : hist_bins[b][INT_BITS-1:0];
      res.frame_done = w.frame_end;
      if (w.frame_end) begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        hist_total  = '0;
        in_map_pass = 1'b0;
      end
    end
  endtask

  // Presents one word and holds it until the block takes it. Inputs change on
  // the falling edge; busy is looked at right after the rising edge, before the
  // block's registers update. When the word is taken, the predictor runs.
  task automatic send_word(input logic [DEPTH_BITS-1:0] depth, input bit last,
                           input bit has_fixed, input logic [INT_BITS-1:0] fixed_int);
    in_word_t  w;
    out_word_t res;
    bit        has_res;
    bit        quiet;
    w.depth     = depth;
    w.frame_end = last;
    quiet       = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_intensity(w, has_res, res);
    if (has_res) begin
      if (has_fixed) res.intensity = fixed_int;
      intensity_q.push_back(res);
    end
    words_sent++;
  endtask

  // One random frame: a counting pass and then a mapping pass. Most frames keep
  // their depths low so that the bin walk stays short; a few use the full
  // range, and now and then the counting pass holds no measurement at all.
  task automatic send_random_frame(input int frame_idx);
    int                    count_len;
    int                    map_len;
    int                    pick;
    int                    depth_top;
    bit                    wide;
    bit                    empty;
    logic [DEPTH_BITS-1:0] d;
    count_len = $urandom_range(10, 60);
    map_len   = $urandom_range(10, 60);
    wide      = (frame_idx % 6 == 2);
    empty     = !wide && ($urandom_range(0, 9) == 0);
    depth_top = ($urandom_range(0, 1) == 0) ? 255 : 1023;
    frame_depths.delete();
    for (int i = 0; i < count_len; i++) begin
      if (empty || $urandom_range(0, 7) == 0) d = '0;
      else if (wide) d = DEPTH_BITS'($urandom_range(0, 65535));
      else d = DEPTH_BITS'($urandom_range(1, depth_top));
      frame_depths.push_back(d);
      send_word(d, i == count_len - 1, 1'b0, '0);
    end
    // The mapping pass mostly repeats depths of the counting pass, with some
    // zeros and some depths that the frame never held.
    for (int i = 0; i < map_len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) d = frame_depths[$urandom_range(0, frame_depths.size() - 1)];
      else if (pick < 80) d = '0;
      else if (pick < 90) d = DEPTH_BITS'($urandom_range(0, 65535));
      else d = DEPTH_BITS'($urandom_range(0, 1023));
      send_word(d, i == map_len - 1, 1'b0, '0);
    end
  endtask

  // Result checker: every strobed word must match the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid) begin
      if (intensity_q.size() == 0) begin
        $error("result word with nothing expected: intensity %0d frame_done %0b",
               out_word.intensity, out_word.frame_done);
        fail_cnt++;
      end else begin
        exp_word = intensity_q.pop_front();
        if (out_word.intensity !== exp_word.intensity) begin
          $error("intensity: expected %0d, got %0d", exp_word.intensity,
                 out_word.intensity);
          fail_cnt++;
        end
        if (out_word.frame_done !== exp_word.frame_done) begin
          $error("frame_done: expected %0b, got %0b", exp_word.frame_done,
                 out_word.frame_done);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog. Every frame pays a clearing sweep over all BINS entries and a bin walk
  // over every bin, some of them through the serial divider, on top of the words themselves
  // and the idle cycles.
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    words_sent  = 0;
    fail_cnt    = 0;
    hist_total  = '0;
    in_map_pass = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = '0;

    // Directed table. The first frame is empty, so every depth maps to zero.
    // The second holds a single sample at depth 100: every bin below it maps
    // to the clamped 255 and the bin itself to zero. The third mixes low bins
    // with depths at and beyond the top bin, which all land in the top bin and
    // therefore map to zero.
    dir_rows = '{
      '{16'd0,     1'b1, 1'b0, 8'd0},
      '{16'd0,     1'b0, 1'b1, 8'd0},
      '{16'd65535, 1'b0, 1'b1, 8'd0},
      '{16'd16383, 1'b1, 1'b1, 8'd0},
      '{16'd100,   1'b1, 1'b0, 8'd0},
      '{16'd50,    1'b0, 1'b1, 8'd255},
      '{16'd1,     1'b0, 1'b1, 8'd255},
      '{16'd100,   1'b0, 1'b1, 8'd0},
      '{16'd101,   1'b1, 1'b1, 8'd0},
      '{16'd1,     1'b0, 1'b0, 8'd0},
      '{16'd2,     1'b0, 1'b0, 8'd0},
      '{16'd2,     1'b0, 1'b0, 8'd0},
      '{16'd16383, 1'b0, 1'b0, 8'd0},
      '{16'd65535, 1'b0, 1'b0, 8'd0},
      '{16'd40000, 1'b0, 1'b0, 8'd0},
      '{16'd0,     1'b1, 1'b0, 8'd0},
      '{16'd0,     1'b0, 1'b1, 8'd0},
      '{16'd1,     1'b0, 1'b0, 8'd0},
      '{16'd2,     1'b0, 1'b0, 8'd0},
      '{16'd5000,  1'b0, 1'b0, 8'd0},
      '{16'd16383, 1'b0, 1'b1, 8'd0},
      '{16'd65535, 1'b0, 1'b1, 8'd0},
      '{16'd32768, 1'b1, 1'b1, 8'd0}
    };

    // Hold synchronous reset, then release it; the block then clears its store with
    // busy high, which the handshake absorbs.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].depth, dir_rows[i].last, dir_rows[i].has_fixed,
                dir_rows[i].fixed_int);

    for (int f = 0; words_sent < WORD_TARGET; f++)
      send_random_frame(f);

    @(negedge clk);
    start <= 1'b0;

    // Drain the outstanding results, then give the clearing sweep that follows
    // the last mapping pass time to finish, so a stray word would still show.
    wait (intensity_q.size() == 0);
    repeat (BINS + 64) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
